### design/av1_temporal_unit_splitter_core_defines.svh
// assertion macros shared by the splitter rtl
`ifndef AV1_TEMPORAL_UNIT_SPLITTER_CORE_DEFINES_SVH
`define AV1_TEMPORAL_UNIT_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AV1TUS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define AV1TUS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/av1tus_pkg.sv
package av1tus_pkg;

   // end status codes of a result beat
   localparam logic [1:0] ST_MORE  = 2'd0;
   localparam logic [1:0] ST_CLEAN = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;
   localparam logic [1:0] ST_LIMIT = 2'd3;

   // obu type of a temporal delimiter
   localparam logic [3:0] OBU_TD = 4'd2;

   localparam int unsigned OUT_BITS  = 32;
   localparam int unsigned UNIT_BITS = 13;

   typedef struct packed {
      logic [OUT_BITS-1:0] unit_offset;
      logic [OUT_BITS-1:0] unit_length;
      logic [1:0]          end_status;
      logic                last_unit;
   } result_type;

   function automatic result_type make_result(input logic [OUT_BITS-1:0] off,
                                              input logic [OUT_BITS-1:0] len,
                                              input logic [1:0]          status,
                                              input logic                last);
      result_type r;
      r.unit_offset = off;
      r.unit_length = len;
      r.end_status  = status;
      r.last_unit   = last;
      return r;
   endfunction

endpackage

### design/av1_temporal_unit_splitter_core.sv
// a result beat enters the result queue when its byte is accepted and is offered from its head
// throughput: one byte per cycle; a byte may cause up to two result beats, which drain one per
// cycle while rsp_stall is low; input stalls while under two of the four queue slots are free
// reset: synchronous, active high; clears the parser, the queue and sets the unit cap to 512
// after a byte marked last the parser returns to its reset state, the unit cap is kept
module av1_temporal_unit_splitter_core #(
   parameter int unsigned POSITION_BITS = 32,
   parameter int unsigned MAX_LEB_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // temporal unit result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_unit_offset,
   output logic [31:0] rsp_unit_length,
   output logic [1:0]  rsp_end_status,
   output logic        rsp_last_unit,
   // unit cap register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_unit_cap
);

`include "av1_temporal_unit_splitter_core_defines.svh"

   localparam int unsigned LEB_BITS = 7 * MAX_LEB_BYTES;
   localparam int unsigned CNT_BITS = $clog2(MAX_LEB_BYTES + 1);
   localparam int unsigned Q_DEPTH  = 4;
   localparam int unsigned Q_PTR    = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT    = $clog2(Q_DEPTH + 1);
   localparam int unsigned UB       = av1tus_pkg::UNIT_BITS;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_EXT     = 3'd1,
      PH_LEB     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_UNSIZED = 3'd4
   } phase_type;

   // parser state
   phase_type                 phase_ff, phase_in;
   logic [POSITION_BITS-1:0]  byte_pos_ff, byte_pos_in;
   logic [3:0]                kind_ff, kind_in;
   logic                      size_present_ff, size_present_in;
   logic [LEB_BITS-1:0]       remaining_ff, remaining_in;
   logic [CNT_BITS-1:0]       leb_cnt_ff, leb_cnt_in;
   logic [POSITION_BITS-1:0]  obu_start_ff, obu_start_in;
   logic [POSITION_BITS-1:0]  unit_start_ff, unit_start_in;
   logic [POSITION_BITS-1:0]  unit_end_ff, unit_end_in;
   logic                      unit_open_ff, unit_open_in;
   logic [UB-1:0]             units_ff, units_in;
   logic                      stopped_ff, stopped_in;
   logic [UB-1:0]             unit_cap_ff, unit_cap_in;

   // result queue
   av1tus_pkg::result_type    queue_ff [Q_DEPTH];
   logic [Q_PTR-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT-1:0]          count_ff, count_in;

   // results of the byte being accepted
   av1tus_pkg::result_type    res [2];
   logic [1:0]                n_res;

   logic                      req_accept;
   logic                      rsp_accept;
   logic                      csr_accept;

   function automatic logic [31:0] to_out(input logic [POSITION_BITS-1:0] v);
      logic [POSITION_BITS+31:0] w;
      w = {32'b0, v};
      return w[31:0];
   endfunction

   // keep room for the worst case of two beats per byte
   assign req_stall  = (count_ff > Q_CNT'(Q_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign rsp_unit_offset = queue_ff[rd_ptr_ff].unit_offset;
   assign rsp_unit_length = queue_ff[rd_ptr_ff].unit_length;
   assign rsp_end_status  = queue_ff[rd_ptr_ff].end_status;
   assign rsp_last_unit   = queue_ff[rd_ptr_ff].last_unit;

   // per-byte parse step
   always_comb begin
      logic [POSITION_BITS-1:0] end_pos;
      logic                     finish;
      logic [POSITION_BITS-1:0] open_len;
      logic [1:0]               end_code;

      phase_in        = phase_ff;
      kind_in         = kind_ff;
      size_present_in = size_present_ff;
      remaining_in    = remaining_ff;
      leb_cnt_in      = leb_cnt_ff;
      obu_start_in    = obu_start_ff;
      unit_start_in   = unit_start_ff;
      unit_end_in     = unit_end_ff;
      unit_open_in    = unit_open_ff;
      units_in        = units_ff;
      stopped_in      = stopped_ff;
      res[0]          = '0;
      res[1]          = '0;
      n_res           = 2'd0;
      finish          = 1'b0;
      open_len        = '0;
      end_code        = av1tus_pkg::ST_MORE;

      end_pos     = byte_pos_ff + POSITION_BITS'(1);
      byte_pos_in = end_pos;

      if (!stopped_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               obu_start_in    = byte_pos_ff;
               kind_in         = req_data_byte[6:3];
               size_present_in = req_data_byte[1];
               remaining_in    = '0;
               leb_cnt_in      = '0;
               if (req_data_byte[2]) begin
                  phase_in = PH_EXT;
               end else begin
                  phase_in = req_data_byte[1] ? PH_LEB : PH_UNSIZED;
               end
            end
            PH_EXT: begin
               phase_in = size_present_ff ? PH_LEB : PH_UNSIZED;
            end
            PH_LEB: begin
               // place this group's seven bits at its slot
               for (int g = 0; g < MAX_LEB_BYTES; g++) begin
                  if (leb_cnt_ff == CNT_BITS'(g)) begin
                     remaining_in[7*g +: 7] = remaining_ff[7*g +: 7] | req_data_byte[6:0];
                  end
               end
               leb_cnt_in = leb_cnt_ff + CNT_BITS'(1);
               // overlong sizes end after the last allowed group
               if (!req_data_byte[7] || (leb_cnt_in >= CNT_BITS'(MAX_LEB_BYTES))) begin
                  if (remaining_in == '0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               remaining_in = remaining_ff - LEB_BITS'(1);
               if (remaining_in == '0) begin
                  finish = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // an unsized obu closes at stream end
         if (req_last_byte && (phase_in == PH_UNSIZED)) begin
            finish = 1'b1;
         end

         if (finish) begin
            phase_in = PH_HEADER;
            if ((kind_in == av1tus_pkg::OBU_TD) || !unit_open_ff) begin
               if (units_ff >= unit_cap_ff) begin
                  // unit limit: flush whatever is open and stop
                  stopped_in = 1'b1;
                  open_len   = unit_end_ff - unit_start_ff;
                  res[0]     = unit_open_ff ?
                     av1tus_pkg::make_result(to_out(unit_start_ff), to_out(open_len),
                                             av1tus_pkg::ST_LIMIT, 1'b1) :
                     av1tus_pkg::make_result('0, '0, av1tus_pkg::ST_LIMIT, 1'b1);
                  n_res      = 2'd1;
               end else begin
                  if (unit_open_ff) begin
                     open_len = unit_end_ff - unit_start_ff;
                     res[0]   = av1tus_pkg::make_result(to_out(unit_start_ff),
                                                        to_out(open_len),
                                                        av1tus_pkg::ST_MORE, 1'b0);
                     n_res    = 2'd1;
                  end
                  unit_start_in = obu_start_in;
                  unit_end_in   = end_pos;
                  unit_open_in  = 1'b1;
                  units_in      = units_ff + UB'(1);
               end
            end else begin
               unit_end_in = end_pos;
            end
         end

         // stream end: emit the open unit (or an empty beat), truncated unless at a header boundary
         if (!stopped_in && req_last_byte) begin
            end_code = (phase_in == PH_HEADER) ? av1tus_pkg::ST_CLEAN : av1tus_pkg::ST_TRUNC;
            open_len = unit_end_in - unit_start_in;
            res[n_res[0]] = unit_open_in ?
               av1tus_pkg::make_result(to_out(unit_start_in), to_out(open_len),
                                       end_code, 1'b1) :
               av1tus_pkg::make_result('0, '0, end_code, 1'b1);
            n_res = n_res + 2'd1;
         end
      end

      if (req_last_byte) begin
         phase_in        = PH_HEADER;
         byte_pos_in     = '0;
         kind_in         = '0;
         size_present_in = 1'b0;
         remaining_in    = '0;
         leb_cnt_in      = '0;
         obu_start_in    = '0;
         unit_start_in   = '0;
         unit_end_in     = '0;
         unit_open_in    = 1'b0;
         units_in        = '0;
         stopped_in      = 1'b0;
      end
   end

   // queue pointer and fill bookkeeping
   always_comb begin
      logic [1:0] pushed;
      pushed    = req_accept ? n_res : 2'd0;
      wr_ptr_in = wr_ptr_ff + Q_PTR'(pushed);
      rd_ptr_in = rd_ptr_ff + Q_PTR'(rsp_accept);
      count_in  = count_ff + Q_CNT'(pushed) - Q_CNT'(rsp_accept);
   end

   assign unit_cap_in = csr_unit_cap;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         byte_pos_ff     <= '0;
         kind_ff         <= '0;
         size_present_ff <= 1'b0;
         remaining_ff    <= '0;
         leb_cnt_ff      <= '0;
         obu_start_ff    <= '0;
         unit_start_ff   <= '0;
         unit_end_ff     <= '0;
         unit_open_ff    <= 1'b0;
         units_ff        <= '0;
         stopped_ff      <= 1'b0;
         unit_cap_ff     <= UB'(512);
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (req_accept) begin
            phase_ff        <= phase_in;
            byte_pos_ff     <= byte_pos_in;
            kind_ff         <= kind_in;
            size_present_ff <= size_present_in;
            remaining_ff    <= remaining_in;
            leb_cnt_ff      <= leb_cnt_in;
            obu_start_ff    <= obu_start_in;
            unit_start_ff   <= unit_start_in;
            unit_end_ff     <= unit_end_in;
            unit_open_ff    <= unit_open_in;
            units_ff        <= units_in;
            stopped_ff      <= stopped_in;
         end
         if (csr_accept) begin
            unit_cap_ff <= unit_cap_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (req_accept && (n_res != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res[0];
         if (n_res == 2'd2) begin
            queue_ff[wr_ptr_ff + Q_PTR'(1)] <= res[1];
         end
      end
   end

   `AV1TUS_ASSERT_NOW(a_queue_bound, 1'b1, count_ff <= Q_CNT'(Q_DEPTH),
      "result queue overfilled")
   `AV1TUS_ASSERT_NOW(a_room_on_accept, req_accept, count_ff <= Q_CNT'(Q_DEPTH - 2),
      "byte taken without room for two beats")
   `AV1TUS_ASSERT_NEXT(a_restart_after_last, req_accept && req_last_byte,
      (byte_pos_ff == '0) && !unit_open_ff && !stopped_ff,
      "parser not back at stream start after last byte")
   `AV1TUS_ASSERT_NOW(a_closed_means_none, !unit_open_ff, units_ff == '0,
      "units counted with no unit open")

endmodule

### tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // size field ends after this many leb128 groups, continuation bit or not
   localparam int unsigned LEB_GROUPS_MAX = 8;
   // generous ceiling on the whole run, in clock cycles
   localparam int unsigned CYCLE_LIMIT    = 200000;
   // cycles allowed after the last expected beat for a byte that causes nothing
   localparam int unsigned SETTLE_CYCLES  = 4;
   // random bytes per register setting
   localparam int unsigned PHASE_BYTES    = 140;
   // mismatch lines printed before going quiet (all are still counted)
   localparam int unsigned PRINT_CAP      = 100;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_EXT,
      PH_LEB,
      PH_PAYLOAD,
      PH_UNSIZED
   } parse_phase_type;

   // tracks the parser, holds the temporal units still owed by the block
   class tu_split_checker;
      logic [12:0]     unit_limit;
      parse_phase_type phase;
      logic [31:0]     position;
      logic [31:0]     obu_at;
      logic [31:0]     unit_start;
      logic [31:0]     unit_stop;
      logic [3:0]      kind;
      logic            sized;
      logic [63:0]     remaining;
      logic [3:0]      groups;
      bit              unit_open;
      bit              stopped;
      logic [12:0]     opened;
      av1tus_pkg::result_type units_due[$];
      int unsigned     mismatches;

      function new();
         unit_limit = 13'd512;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase      = PH_HEADER;
         position   = '0;
         obu_at     = '0;
         unit_start = '0;
         unit_stop  = '0;
         kind       = '0;
         sized      = 1'b0;
         remaining  = '0;
         groups     = '0;
         unit_open  = 1'b0;
         stopped    = 1'b0;
         opened     = '0;
      endfunction

      function void set_limit(input logic [12:0] value);
         unit_limit = value;
      endfunction

      function void queue_unit(input logic [31:0] off, input logic [31:0] len,
                               input logic [1:0] status, input logic lst);
         av1tus_pkg::result_type r;
         r.unit_offset = off;
         r.unit_length = len;
         r.end_status  = status;
         r.last_unit   = lst;
         units_due.push_back(r);
      endfunction

      // final beat of a stream: the open unit, or an empty one carrying the status
      function void close_stream(input logic [1:0] status);
         if (unit_open)
            queue_unit(unit_start, unit_stop - unit_start, status, 1'b1);
         else
            queue_unit('0, '0, status, 1'b1);
      endfunction

      function void finish_obu(input logic [31:0] stop);
         phase = PH_HEADER;
         if (kind == av1tus_pkg::OBU_TD || !unit_open) begin
            if (opened >= unit_limit) begin
               stopped = 1'b1;
               close_stream(av1tus_pkg::ST_LIMIT);
               return;
            end
            if (unit_open)
               queue_unit(unit_start, unit_stop - unit_start, av1tus_pkg::ST_MORE, 1'b0);
            unit_start = obu_at;
            unit_stop  = stop;
            unit_open  = 1'b1;
            opened     = opened + 13'd1;
         end else begin
            unit_stop = stop;
         end
      endfunction

      // one accepted byte beat
      function void take_byte(input logic [7:0] b, input logic lst);
         logic [31:0] here;
         logic [31:0] next_pos;
         here     = position;
         next_pos = position + 32'd1;
         position = next_pos;
         if (!stopped) begin
            case (phase)
               PH_HEADER: begin
                  obu_at    = here;
                  kind      = b[6:3];
                  sized     = b[1];
                  remaining = '0;
                  groups    = '0;
                  if (b[2])
                     phase = PH_EXT;
                  else
                     phase = sized ? PH_LEB : PH_UNSIZED;
               end
               PH_EXT: begin
                  phase = sized ? PH_LEB : PH_UNSIZED;
               end
               PH_LEB: begin
                  remaining = remaining | (64'(b[6:0]) << (7 * groups[2:0]));
                  groups    = groups + 4'd1;
                  if (!b[7] || groups >= LEB_GROUPS_MAX) begin
                     if (remaining == 0)
                        finish_obu(next_pos);
                     else
                        phase = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  remaining = remaining - 64'd1;
                  if (remaining == 0)
                     finish_obu(next_pos);
               end
               default: ;
            endcase
            if (!stopped && lst && phase == PH_UNSIZED)
               finish_obu(next_pos);
            if (!stopped && lst)
               close_stream(phase == PH_HEADER ? av1tus_pkg::ST_CLEAN : av1tus_pkg::ST_TRUNC);
         end
         if (lst)
            restart();
      endfunction

      task report(input string what);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("%0t ns mismatch: %s", $realtime, what);
      endtask

      // one accepted result beat against the oldest owed unit
      task check_unit(input av1tus_pkg::result_type got);
         av1tus_pkg::result_type want;
         if (units_due.size() == 0) begin
            report($sformatf("unexpected unit off=%0d len=%0d st=%0d last=%0b",
                             got.unit_offset, got.unit_length, got.end_status,
                             got.last_unit));
            return;
         end
         want = units_due.pop_front();
         if (got.unit_offset !== want.unit_offset)
            report($sformatf("unit_offset %0d, want %0d", got.unit_offset,
                             want.unit_offset));
         if (got.unit_length !== want.unit_length)
            report($sformatf("unit_length %0d, want %0d", got.unit_length,
                             want.unit_length));
         if (got.end_status !== want.end_status)
            report($sformatf("end_status %0d, want %0d", got.end_status,
                             want.end_status));
         if (got.last_unit !== want.last_unit)
            report($sformatf("last_unit %0b, want %0b", got.last_unit,
                             want.last_unit));
      endtask
   endclass

   // block ports; the inputs are known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_unit_offset;
   logic [31:0] rsp_unit_length;
   logic [1:0]  rsp_end_status;
   logic        rsp_last_unit;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_unit_cap = 13'd512;

   tu_split_checker units;
   logic [7:0]      stream_bytes[$];
   bit              quiet = 1'b0;
   int unsigned     bytes_sent = 0;
   int unsigned     cycle_count = 0;
   int unsigned     stall_left = 0;
   int unsigned     calm_left = 0;
   logic [12:0]     limits[8];

   av1_temporal_unit_splitter_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_unit_offset (rsp_unit_offset),
      .rsp_unit_length (rsp_unit_length),
      .rsp_end_status  (rsp_end_status),
      .rsp_last_unit   (rsp_last_unit),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_unit_cap    (csr_unit_cap)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // receiver back-pressure: random bursts of stalled cycles, with calm stretches between
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (calm_left != 0)
            calm_left--;
         else if ($urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 6);
         else if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(20, 60);
      end
   end

   // result monitor: every accepted beat is checked against the oldest owed unit
   always @(posedge clock) begin
      av1tus_pkg::result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.unit_offset = rsp_unit_offset;
         seen.unit_length = rsp_unit_length;
         seen.end_status  = rsp_end_status;
         seen.last_unit   = rsp_last_unit;
         units.check_unit(seen);
      end
   end

   // one byte beat; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic lst);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         // sender idles for a short burst
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      do @(posedge clock); while (req_stall);
      units.take_byte(b, lst);
      bytes_sent++;
      @(negedge clock);
   endtask

   // whole stream, last flag on its final byte
   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++)
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   // sender holds off until every owed unit is back and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (units.units_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // unit cap write, only ever issued with the block idle
   task automatic write_unit_limit(input logic [12:0] value);
      csr_valid    <= 1'b1;
      csr_unit_cap <= value;
      do @(posedge clock); while (!csr_ready);
      units.set_limit(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed obu streams with random content, some noise and some cut short
   task automatic build_stream();
      int unsigned obus, n, keep, need, style, grp;
      logic [3:0]  kind;
      logic        ext, sized;
      logic [63:0] rest;
      stream_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         // noise: random bytes with whatever headers and sizes they happen to make
         n = $urandom_range(1, 12);
         repeat (n) stream_bytes.push_back(8'($urandom));
      end else begin
         obus = $urandom_range(1, 8);
         for (int i = 0; i < obus; i++) begin
            // delimiters common, and usually first so units open the usual way
            if ($urandom_range(0, 2) == 0 || (i == 0 && $urandom_range(0, 2) != 0))
               kind = av1tus_pkg::OBU_TD;
            else
               kind = 4'($urandom);
            ext   = ($urandom_range(0, 3) == 0);
            // only the last obu may run to the end of the stream unsized
            sized = (i != obus - 1) || ($urandom_range(0, 5) != 0);
            stream_bytes.push_back({1'($urandom), kind, ext, sized, 1'($urandom)});
            if (ext)
               stream_bytes.push_back(8'($urandom));
            if (!sized)
               n = $urandom_range(0, 6);
            else if (kind == av1tus_pkg::OBU_TD)
               n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            else if ($urandom_range(0, 15) == 0)
               n = $urandom_range(128, 200);
            else
               n = $urandom_range(0, 12);
            if (sized) begin
               // leb128: minimal, zero-padded, or overlong with every continuation bit set
               rest = 64'(n);
               need = 1;
               while ((rest >> (7 * need)) != 0) need++;
               style = $urandom_range(0, 7);
               if (style == 0)
                  grp = $urandom_range(need, LEB_GROUPS_MAX);
               else if (style == 1)
                  grp = LEB_GROUPS_MAX;
               else
                  grp = need;
               for (int g = 0; g < grp; g++) begin
                  stream_bytes.push_back({(g < grp - 1) || (style == 1), rest[6:0]});
                  rest = rest >> 7;
               end
            end
            repeat (n) stream_bytes.push_back(8'($urandom));
         end
         // now and then the stream is cut off mid-obu
         if ($urandom_range(0, 5) == 0) begin
            keep = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
         end
      end
   endtask

   initial begin
      units = new();

      // unit limit per phase: extremes, tiny limits that stop parsing, wide values
      limits[0] = 13'd1;
      limits[1] = 13'd4096;
      limits[2] = 13'd2;
      limits[3] = 13'd3;
      limits[4] = 13'd4095;
      limits[5] = 13'($urandom_range(1, 8));
      limits[6] = 13'd1;
      limits[7] = 13'd512;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed streams, register still at its reset value
      // lone delimiter header: truncated with nothing open
      stream_bytes = {8'h12};
      send_stream();
      // header wanting an extension byte: truncated with nothing open
      stream_bytes = {8'hFF};
      send_stream();
      // unsized obu that is the whole stream: one byte unit, clean end
      stream_bytes = {8'h00};
      send_stream();
      // empty delimiter, frame with extension and one payload byte,
      // delimiter with an overlong size of eight zero groups, unsized tail
      stream_bytes = {8'h12, 8'h00, 8'h36, 8'hFF, 8'h01, 8'hFF,
                      8'h12, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                      8'h08};
      send_stream();
      // payload cut short with a unit open
      stream_bytes = {8'h12, 8'h00, 8'h32, 8'h05, 8'hAA};
      send_stream();
      drain();

      // random streams under each register setting; no idling in the last two
      for (int p = 0; p < 8; p++) begin
         if (p >= 6)
            quiet = 1'b1;
         write_unit_limit(limits[p]);
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) begin
            build_stream();
            send_stream();
         end
         drain();
      end

      if (units.mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
